@@ design/mas_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_pkg
// Types and constants shared by the motion alarm sequencer modules.
// ----------------------------------------------------------------------------
package mas_pkg;

    // ADC sample width and chirps per low-battery warning
    localparam int ADC_BITS    = 10;
    localparam int CHIRP_COUNT = 3;
    localparam int RAW_W       = 10;

    // battery scaling: mv = raw * DIVIDER_GAIN * REF_MV / 2^ADC_BITS
    localparam int DIVIDER_GAIN = 2;
    localparam int REF_MV       = 5000;
    localparam int MV_SCALE     = DIVIDER_GAIN * REF_MV;
    localparam int PROD_W       = RAW_W + 14;

    localparam logic [15:0] CHIRP_ON_TICKS  = 16'd1;
    localparam logic [15:0] CHIRP_OFF_TICKS = 16'd2;
    localparam logic [15:0] TICK_MAX        = 16'hFFFF;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BATTERY_MV     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_PAIRS         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_TICKS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_TICKS         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_POLL_TICKS = 3'd4;

    localparam logic [13:0] RST_LOW_BATTERY_MV     = 14'd6400;
    localparam logic [7:0]  RST_BEEP_PAIRS         = 8'd10;
    localparam logic [15:0] RST_WARMUP_TICKS       = 16'd1024;
    localparam logic [7:0]  RST_BEEP_TICKS         = 8'd8;
    localparam logic [7:0]  RST_RELEASE_POLL_TICKS = 8'd16;

    typedef enum logic [2:0] {
        PH_WARMUP  = 3'd0,
        PH_ARMBEEP = 3'd1,
        PH_CHIRP   = 3'd2,
        PH_ARMED   = 3'd3,
        PH_ALARM   = 3'd4,
        PH_RELEASE = 3'd5
    } t_phase;

    // input item action codes
    localparam logic ACT_TICK      = 1'b0;
    localparam logic ACT_PIN_EVENT = 1'b1;

    typedef struct packed {
        logic             action;
        logic             pir_level;
        logic [RAW_W-1:0] battery_raw;
    } t_in_item;

    typedef struct packed {
        logic       buzzer;
        logic [2:0] phase;
        logic       low_battery;
    } t_out_item;

    typedef struct packed {
        logic [13:0] low_battery_mv;
        logic [7:0]  beep_pairs;
        logic [15:0] warmup_ticks;
        logic [7:0]  beep_ticks;
        logic [7:0]  release_poll_ticks;
    } t_cfg;

endpackage

@@ design/mas_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module mas_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mas_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mas_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output mas_pkg::t_cfg                    o_cfg
);
    import mas_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_battery_mv     <= RST_LOW_BATTERY_MV;
            r_cfg.beep_pairs         <= RST_BEEP_PAIRS;
            r_cfg.warmup_ticks       <= RST_WARMUP_TICKS;
            r_cfg.beep_ticks         <= RST_BEEP_TICKS;
            r_cfg.release_poll_ticks <= RST_RELEASE_POLL_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOW_BATTERY_MV:     r_cfg.low_battery_mv     <= i_cfg_wdata[13:0];
                CFG_BEEP_PAIRS:         r_cfg.beep_pairs         <= i_cfg_wdata[7:0];
                CFG_WARMUP_TICKS:       r_cfg.warmup_ticks       <= i_cfg_wdata[15:0];
                CFG_BEEP_TICKS:         r_cfg.beep_ticks         <= i_cfg_wdata[7:0];
                CFG_RELEASE_POLL_TICKS: r_cfg.release_poll_ticks <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/mas_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_fsm
// Alarm sequencer state and next-state logic; advances once per request.
// ----------------------------------------------------------------------------
module mas_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  mas_pkg::t_in_item   i_item,
    input  mas_pkg::t_cfg       i_cfg,
    output mas_pkg::t_out_item  o_result
);
    import mas_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [15:0] r_tick,   n_tick;
    logic [7:0]  r_beeps,  n_beeps;
    logic [1:0]  r_chirps, n_chirps;
    logic        r_sound,  n_sound;
    logic        r_low,    n_low;

    logic [15:0]       tick_inc;
    logic [RAW_W-1:0]  raw_masked;
    logic [PROD_W-1:0] mv_prod;
    logic [PROD_W-1:0] mv;
    logic              batt_low;
    logic [1:0]        chirp_init;
    logic [1:0]        chirps_dec;
    logic [7:0]        beeps_dec;

    // battery scaling by constant multiply and shift
    assign raw_masked = i_item.battery_raw & RAW_W'((1 << ADC_BITS) - 1);
    assign mv_prod    = PROD_W'(raw_masked) * PROD_W'(MV_SCALE);
    assign mv         = mv_prod >> ADC_BITS;
    assign batt_low   = mv < PROD_W'(i_cfg.low_battery_mv);
    assign chirp_init = 2'(CHIRP_COUNT);

    assign tick_inc   = (r_tick == TICK_MAX) ? r_tick : r_tick + 16'd1;
    assign chirps_dec = r_chirps - 2'd1;
    assign beeps_dec  = r_beeps - 8'd1;

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_beeps  = r_beeps;
        n_chirps = r_chirps;
        n_sound  = r_sound;
        n_low    = r_low;
        if (i_item.action == ACT_PIN_EVENT) begin
            if (r_phase == PH_ARMED && i_item.pir_level) begin
                n_tick  = '0;
                n_beeps = i_cfg.beep_pairs;
                if (i_cfg.beep_pairs == 8'd0) begin
                    n_sound = 1'b0;
                    n_phase = PH_RELEASE;
                end else begin
                    n_sound = 1'b1;
                    n_phase = PH_ALARM;
                end
            end
        end else begin
            case (r_phase)
                PH_WARMUP: begin
                    n_tick = tick_inc;
                    if (tick_inc >= i_cfg.warmup_ticks) begin
                        n_tick  = '0;
                        n_sound = 1'b1;
                        n_phase = PH_ARMBEEP;
                    end
                end
                PH_ARMBEEP: begin
                    n_tick = tick_inc;
                    if (tick_inc >= {8'd0, i_cfg.beep_ticks}) begin
                        n_tick  = '0;
                        n_low   = batt_low;
                        n_sound = 1'b0;
                        n_phase = PH_ARMED;
                        if (batt_low) begin
                            n_chirps = chirp_init;
                            if (chirp_init != 2'd0) begin
                                n_sound = 1'b1;
                                n_phase = PH_CHIRP;
                            end
                        end
                    end
                end
                PH_CHIRP: begin
                    n_tick = tick_inc;
                    if (r_sound) begin
                        if (tick_inc >= CHIRP_ON_TICKS) begin
                            n_sound = 1'b0;
                            n_tick  = '0;
                        end
                    end else if (tick_inc >= CHIRP_OFF_TICKS) begin
                        n_tick   = '0;
                        n_chirps = chirps_dec;
                        if (chirps_dec == 2'd0) begin
                            n_phase = PH_ARMED;
                        end else begin
                            n_sound = 1'b1;
                        end
                    end
                end
                PH_ALARM: begin
                    n_tick = tick_inc;
                    if (tick_inc >= {8'd0, i_cfg.beep_ticks}) begin
                        n_tick = '0;
                        if (r_sound) begin
                            n_sound = 1'b0;
                        end else begin
                            n_beeps = beeps_dec;
                            if (beeps_dec == 8'd0) begin
                                n_sound = 1'b0;
                                if (i_item.pir_level) begin
                                    n_phase = PH_RELEASE;
                                end else begin
                                    n_low   = batt_low;
                                    n_phase = PH_ARMED;
                                    if (batt_low) begin
                                        n_chirps = chirp_init;
                                        if (chirp_init != 2'd0) begin
                                            n_sound = 1'b1;
                                            n_phase = PH_CHIRP;
                                        end
                                    end
                                end
                            end else begin
                                n_sound = 1'b1;
                            end
                        end
                    end
                end
                PH_RELEASE: begin
                    n_tick = tick_inc;
                    if (tick_inc >= {8'd0, i_cfg.release_poll_ticks}) begin
                        n_tick = '0;
                        if (!i_item.pir_level) begin
                            n_low   = batt_low;
                            n_sound = 1'b0;
                            n_phase = PH_ARMED;
                            if (batt_low) begin
                                n_chirps = chirp_init;
                                if (chirp_init != 2'd0) begin
                                    n_sound = 1'b1;
                                    n_phase = PH_CHIRP;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result of this request, taken from the updated state
    always_comb begin
        o_result.buzzer      = n_sound;
        o_result.phase       = 3'(n_phase);
        o_result.low_battery = n_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WARMUP;
            r_tick   <= '0;
            r_beeps  <= '0;
            r_chirps <= '0;
            r_sound  <= 1'b0;
            r_low    <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_beeps  <= n_beeps;
            r_chirps <= n_chirps;
            r_sound  <= n_sound;
            r_low    <= n_low;
        end
    end

endmodule

@@ design/motion_alarm_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_alarm_sequencer_top
// Motion-sensor alarm sequencer: warm-up, arming beep, battery check with
// low-battery chirps, intrusion beep runs and release polling, stepped by
// 64 ms ticks and sensor pin-change requests.
// ----------------------------------------------------------------------------
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  input   | i_in_valid, o_in_stall, i_in_item            | in
//  output  | o_out_valid, i_out_stall, o_out_item         | out
//  config  | i_cfg_we, i_cfg_idx, i_cfg_wdata             | in
//
//  One request per cycle sustained while results are not stalled; each
//  request passes the input register, then the state update, then the result register.
//  Synchronous active-low reset returns the sequencer to warm-up and the
//  configuration registers to their defaults.
//  A stalled result holds in the result register while one more request
//  waits in the input register; input stall rises only when both are full.
// ----------------------------------------------------------------------------
module motion_alarm_sequencer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  mas_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mas_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_we,
    input  logic [mas_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mas_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import mas_pkg::*;

    t_cfg      cfg;
    t_out_item result;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_free;
    logic      step;

    // the result register can take a new result when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    mas_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mas_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register: load whenever not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // result register: advance on a step, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ dv/motion_alarm_sequencer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_alarm_sequencer_checker
// Watches the request, result and register ports of the alarm sequencer,
// predicts every result from its own copy of the sequencer state and
// compares each delivered result, field by field, in order.
// ----------------------------------------------------------------------------
module motion_alarm_sequencer_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  mas_pkg::t_in_item              i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  mas_pkg::t_out_item             i_out_item,
    input  logic                           i_cfg_we,
    input  logic [mas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mas_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output logic [5:0]                     o_phases_seen
);

    import mas_pkg::*;

    // shadow registers and sequencer state
    t_cfg        cfg;
    t_phase      phase_q;
    logic [15:0] tick_q;
    logic [7:0]  beeps_q;
    logic [1:0]  chirps_q;
    logic        buzz_q;
    logic        low_q;

    t_out_item   alarm_outputs_due[$];
    t_out_item   want;
    t_out_item   next_out;

    task automatic count_tick();
        if (tick_q != TICK_MAX) begin
            tick_q = tick_q + 16'd1;
        end
    endtask

    task automatic check_battery(input logic [RAW_W-1:0] raw);
        int unsigned mv;
        mv = ((32'(raw) & ((32'd1 << ADC_BITS) - 32'd1)) * 32'(MV_SCALE)) >> ADC_BITS;
        tick_q = '0;
        if (mv < 32'(cfg.low_battery_mv)) begin
            low_q    = 1'b1;
            chirps_q = 2'(CHIRP_COUNT);
            buzz_q   = (chirps_q != 2'd0);
            phase_q  = (chirps_q != 2'd0) ? PH_CHIRP : PH_ARMED;
        end else begin
            low_q   = 1'b0;
            buzz_q  = 1'b0;
            phase_q = PH_ARMED;
        end
    endtask

    task automatic finish_run(input logic level, input logic [RAW_W-1:0] raw);
        buzz_q = 1'b0;
        tick_q = '0;
        if (!level) begin
            check_battery(raw);
        end else begin
            phase_q = PH_RELEASE;
        end
    endtask

    task automatic step_sequencer(input t_in_item req, output t_out_item res);
        if (req.action == ACT_PIN_EVENT) begin
            if (phase_q == PH_ARMED && req.pir_level) begin
                tick_q  = '0;
                beeps_q = cfg.beep_pairs;
                if (beeps_q == 8'd0) begin
                    finish_run(req.pir_level, req.battery_raw);
                end else begin
                    buzz_q  = 1'b1;
                    phase_q = PH_ALARM;
                end
            end
        end else begin
            case (phase_q)
                PH_WARMUP: begin
                    count_tick();
                    if (tick_q >= cfg.warmup_ticks) begin
                        tick_q  = '0;
                        buzz_q  = 1'b1;
                        phase_q = PH_ARMBEEP;
                    end
                end
                PH_ARMBEEP: begin
                    count_tick();
                    if (tick_q >= 16'(cfg.beep_ticks)) begin
                        buzz_q = 1'b0;
                        check_battery(req.battery_raw);
                    end
                end
                PH_CHIRP: begin
                    count_tick();
                    if (buzz_q) begin
                        if (tick_q >= CHIRP_ON_TICKS) begin
                            buzz_q = 1'b0;
                            tick_q = '0;
                        end
                    end else if (tick_q >= CHIRP_OFF_TICKS) begin
                        tick_q   = '0;
                        chirps_q = chirps_q - 2'd1;
                        if (chirps_q == 2'd0) begin
                            phase_q = PH_ARMED;
                        end else begin
                            buzz_q = 1'b1;
                        end
                    end
                end
                PH_ALARM: begin
                    count_tick();
                    if (tick_q >= 16'(cfg.beep_ticks)) begin
                        tick_q = '0;
                        if (buzz_q) begin
                            buzz_q = 1'b0;
                        end else begin
                            beeps_q = beeps_q - 8'd1;
                            if (beeps_q == 8'd0) begin
                                finish_run(req.pir_level, req.battery_raw);
                            end else begin
                                buzz_q = 1'b1;
                            end
                        end
                    end
                end
                PH_RELEASE: begin
                    count_tick();
                    if (tick_q >= 16'(cfg.release_poll_ticks)) begin
                        tick_q = '0;
                        if (!req.pir_level) begin
                            check_battery(req.battery_raw);
                        end
                    end
                end
                default: ;
            endcase
        end
        res.buzzer      = buzz_q;
        res.phase       = phase_q;
        res.low_battery = low_q;
    endtask

    task automatic check_field(input string name, input logic [2:0] exp_v,
                               input logic [2:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.low_battery_mv     = RST_LOW_BATTERY_MV;
            cfg.beep_pairs         = RST_BEEP_PAIRS;
            cfg.warmup_ticks       = RST_WARMUP_TICKS;
            cfg.beep_ticks         = RST_BEEP_TICKS;
            cfg.release_poll_ticks = RST_RELEASE_POLL_TICKS;
            phase_q       = PH_WARMUP;
            tick_q        = '0;
            beeps_q       = '0;
            chirps_q      = '0;
            buzz_q        = 1'b0;
            low_q         = 1'b0;
            alarm_outputs_due.delete();
            o_fail_count  = 0;
            o_checked     = 0;
            o_phases_seen = '0;
        end else begin
            // results first: a request taken on this edge cannot be answered yet
            if (i_out_valid && !i_out_stall) begin
                if (alarm_outputs_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d/%0d/%0d",
                             $time, i_out_item.buzzer, i_out_item.phase,
                             i_out_item.low_battery);
                    o_fail_count++;
                end else begin
                    want = alarm_outputs_due.pop_front();
                    o_checked++;
                    check_field("buzzer", 3'(want.buzzer), 3'(i_out_item.buzzer));
                    check_field("phase", want.phase, i_out_item.phase);
                    check_field("low_battery", 3'(want.low_battery),
                                3'(i_out_item.low_battery));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_sequencer(i_in_item, next_out);
                alarm_outputs_due.push_back(next_out);
                o_phases_seen[phase_q] = 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOW_BATTERY_MV:     cfg.low_battery_mv     = i_cfg_wdata[13:0];
                    CFG_BEEP_PAIRS:         cfg.beep_pairs         = i_cfg_wdata[7:0];
                    CFG_WARMUP_TICKS:       cfg.warmup_ticks       = i_cfg_wdata[15:0];
                    CFG_BEEP_TICKS:         cfg.beep_ticks         = i_cfg_wdata[7:0];
                    CFG_RELEASE_POLL_TICKS: cfg.release_poll_ticks = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
        o_pending = alarm_outputs_due.size();
    end

endmodule

@@ dv/motion_alarm_sequencer_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_alarm_sequencer_top_test
// Drives the alarm sequencer with tick and sensor pin-change requests under
// a series of register settings, with random gaps and result stalls; a
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module motion_alarm_sequencer_top_test;

    import mas_pkg::*;

    // an index with no register behind it: writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    localparam int RANDOM_ITEMS = 1800;
    localparam int MAX_GAP      = 18;
    localparam int LONG_HOLD    = 300;  // result hold-off that backs up the block
    localparam int DRAIN_CYCLES = 4;    // settling margin after the last result
    localparam int HOLD_PHASE   = 4;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    t_in_item              req_item;
    logic                  res_valid;
    logic                  res_stall;
    t_out_item             res_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int                    fail_count;
    int                    pending_count;
    int                    checked_count;
    logic [5:0]            phases_seen;

    // stimulus bookkeeping
    logic                  tx_burst;      // sender offers back to back
    logic                  rx_burst;      // receiver never stalls
    logic                  hold_off_req;  // ask the receiver for one long stall
    logic [13:0]           low_mv_now;    // threshold last written, to aim raw samples
    int                    sent_count;
    int                    pin_count;
    int                    write_count;
    int                    long_holds;

    motion_alarm_sequencer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_item   (req_item),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_item  (res_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    motion_alarm_sequencer_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (req_valid),
        .i_in_stall    (req_stall),
        .i_in_item     (req_item),
        .i_out_valid   (res_valid),
        .i_out_stall   (res_stall),
        .i_out_item    (res_item),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count),
        .o_checked     (checked_count),
        .o_phases_seen (phases_seen)
    );

    // 10 ns clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic t_in_item pack_request(input logic act, input logic pir,
                                              input logic [RAW_W-1:0] raw);
        t_in_item it;
        it.action      = act;
        it.pir_level   = pir;
        it.battery_raw = raw;
        return it;
    endfunction

    // Offer one request. Start at the falling edge after the previous
    // acceptance, drop valid for the drawn gap, then hold the payload until
    // the block takes it. Return right after the accepting rising edge so the
    // next call can keep valid high without toggling it.
    task automatic send_request(input t_in_item it);
        int unsigned gap;
        @(negedge clk);
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_item  <= it;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        sent_count++;
        if (it.action == ACT_PIN_EVENT) begin
            pin_count++;
        end
    endtask

    // Stop offering, wait until every predicted result has been delivered,
    // then let the pipeline settle before anyone touches the registers.
    task automatic wait_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register write; the enable is high for exactly one rising edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        write_count++;
        if (idx == CFG_LOW_BATTERY_MV) begin
            low_mv_now = value[13:0];
        end
    endtask

    // Result side: draw a stall length per result, with stretches of no
    // stalling, and one long hold-off when the stimulus asks for it.
    initial begin : result_sink
        int unsigned hold;
        res_stall = 1'b0;
        rx_burst  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold         = LONG_HOLD;
                hold_off_req = 1'b0;
                long_holds++;
            end else begin
                hold = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if ($urandom_range(0, 63) == 0) begin
                rx_burst = ~rx_burst;
            end
            if (hold != 0) begin
                res_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    initial begin : stimulus
        t_in_item    it;
        logic        sensor;
        logic [7:0]  beeps;
        logic [7:0]  beep_len;
        logic [7:0]  poll_len;
        logic [13:0] mv_lim;
        logic [15:0] warm;
        int          phase_no;
        int          random_base;
        int          aim;
        int          n;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_item     = '0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_wdata    = '0;
        tx_burst     = 1'b0;
        hold_off_req = 1'b0;
        low_mv_now   = RST_LOW_BATTERY_MV;
        sent_count   = 0;
        pin_count    = 0;
        write_count  = 0;
        long_holds   = 0;
        sensor       = 1'b0;

        // hold reset, then release it away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---------------- directed part ----------------
        // Zero warm-up ends on the first tick. Threshold 9990 mV sits right
        // at full scale: raw 1023 reads 9990 (not low), raw 1022 reads 9980.
        write_reg(CFG_WARMUP_TICKS, 16'd0);
        write_reg(CFG_BEEP_TICKS, 16'd1);
        write_reg(CFG_BEEP_PAIRS, 16'd1);
        write_reg(CFG_RELEASE_POLL_TICKS, 16'd1);
        write_reg(CFG_LOW_BATTERY_MV, 16'd9990);
        write_reg(CFG_IDX_SPARE, 16'hFFFF);

        send_request(pack_request(ACT_PIN_EVENT, 1'b1, 10'd0));    // ignored in warm-up
        send_request(pack_request(ACT_TICK, 1'b0, 10'd0));         // warm-up over, arming beep
        send_request(pack_request(ACT_TICK, 1'b0, 10'd1022));      // beep ends, battery low
        // every chirp is one tick on and two off
        repeat (CHIRP_COUNT * 3) begin
            send_request(pack_request(ACT_TICK, 1'b1, 10'($urandom)));
        end
        send_request(pack_request(ACT_TICK, 1'b1, 10'h3FF));       // armed ticks change nothing
        send_request(pack_request(ACT_PIN_EVENT, 1'b0, 10'h3FF));  // level low: ignored
        send_request(pack_request(ACT_PIN_EVENT, 1'b1, 10'h000));  // intrusion
        send_request(pack_request(ACT_TICK, 1'b1, 10'h000));       // beep off
        send_request(pack_request(ACT_TICK, 1'b1, 10'h000));       // gap ends, sensor high
        send_request(pack_request(ACT_TICK, 1'b0, 10'd1023));      // released, battery fine

        // zero beeps per intrusion: straight to the release wait
        wait_until_drained();
        write_reg(CFG_BEEP_PAIRS, 16'd0);
        write_reg(CFG_BEEP_TICKS, 16'd200);
        send_request(pack_request(ACT_PIN_EVENT, 1'b1, 10'h155));
        send_request(pack_request(ACT_TICK, 1'b0, 10'd1023));

        // start a slow run, then shorten the beep under it: the next tick
        // ends the wait; the run ends with the sensor low and re-arms at once
        wait_until_drained();
        write_reg(CFG_BEEP_PAIRS, 16'd2);
        send_request(pack_request(ACT_PIN_EVENT, 1'b1, 10'h2AA));
        send_request(pack_request(ACT_TICK, 1'b1, 10'h2AA));
        send_request(pack_request(ACT_TICK, 1'b1, 10'h2AA));
        wait_until_drained();
        write_reg(CFG_BEEP_TICKS, 16'd0);
        repeat (3) send_request(pack_request(ACT_TICK, 1'b1, 10'h000));
        send_request(pack_request(ACT_TICK, 1'b0, 10'd512));

        // ---------------- random part ----------------
        // Each phase drains the block, writes a fresh setting of every
        // register (junk in the unused upper data bits), then runs a batch.
        random_base = sent_count;
        phase_no    = 0;
        while (sent_count - random_base < RANDOM_ITEMS) begin
            wait_until_drained();

            beeps    = 8'($urandom_range(1, 4));
            beep_len = 8'($urandom_range(1, 3));
            poll_len = 8'($urandom_range(1, 4));
            case (phase_no)
                1: begin
                    beep_len = 8'd255;
                    beeps    = 8'd1;
                end
                2: begin
                    beeps    = 8'd255;
                    beep_len = 8'd1;
                end
                3: poll_len = 8'd255;
                5: begin
                    beeps    = '0;
                    beep_len = '0;
                    poll_len = '0;
                end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        beeps = '0;
                    end
                end
            endcase
            if (phase_no % 4 == 1) begin
                mv_lim = 14'd0;
            end else if (phase_no % 4 == 3) begin
                mv_lim = 14'd10000;
            end else begin
                mv_lim = 14'($urandom_range(0, 10000));
            end
            warm = (phase_no == 2) ? 16'hFFFF : 16'($urandom);

            write_reg(CFG_LOW_BATTERY_MV, {2'($urandom), mv_lim});
            write_reg(CFG_BEEP_PAIRS, {8'($urandom), beeps});
            write_reg(CFG_WARMUP_TICKS, warm);
            write_reg(CFG_BEEP_TICKS, {8'($urandom), beep_len});
            write_reg(CFG_RELEASE_POLL_TICKS, {8'($urandom), poll_len});

            tx_burst = ($urandom_range(0, 3) == 0);
            // one phase: sender floods while the receiver holds off
            if (phase_no == HOLD_PHASE) begin
                tx_burst     = 1'b1;
                hold_off_req = 1'b1;
            end

            n = $urandom_range(60, 150);
            repeat (n) begin
                // the sensor level wanders on its own; a pin change flips it
                if ($urandom_range(0, 19) == 0) begin
                    sensor = ~sensor;
                end
                it.action = ($urandom_range(0, 6) == 0) ? ACT_PIN_EVENT : ACT_TICK;
                if (it.action == ACT_PIN_EVENT) begin
                    sensor = ~sensor;
                end
                it.pir_level = sensor;
                // a little noise: level that disagrees with the pin history
                if ($urandom_range(0, 19) == 0) begin
                    it.pir_level = 1'($urandom);
                end
                // half the samples land within a couple of codes of the threshold
                if ($urandom_range(0, 1) == 0) begin
                    it.battery_raw = 10'($urandom);
                end else begin
                    aim = int'(low_mv_now) * 1024 / 10000 + int'($urandom_range(0, 4)) - 2;
                    if (aim < 0) begin
                        aim = 0;
                    end else if (aim > 1023) begin
                        aim = 1023;
                    end
                    it.battery_raw = 10'(aim);
                end
                send_request(it);
            end
            phase_no++;
        end

        // ---------------- wind down ----------------
        wait_until_drained();
        $display("Run covered %0d requests (%0d pin changes) over %0d register writes, %0d long result hold-offs.",
                 sent_count, pin_count, write_count, long_holds);
        $display("Checked %0d results; phases reached (bit per phase, 5..0): %b.",
                 checked_count, phases_seen);
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/mas_pkg.sv
design/mas_cfg_regs.sv
design/mas_fsm.sv
design/motion_alarm_sequencer_top.sv
dv/motion_alarm_sequencer_checker.sv
dv/motion_alarm_sequencer_top_test.sv
